// ----- src/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, codes and types for the min tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int DATA_W      = 32;
	localparam int WORD_W      = DATA_W + 2;              // encoded entry width
	localparam int PTR_W       = $clog2(STACK_DEPTH);     // entry address
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1); // fill count

	localparam logic signed [DATA_W-1:0] MIN_RESET = {1'b0, {(DATA_W-1){1'b1}}};

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic                     is_empty;
		logic [1:0]               error_code;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
	} mem_wr_t;

	typedef struct packed {
		logic             re;
		logic [PTR_W-1:0] raddr;
	} mem_rd_t;

endpackage

// ----- src/mts_intf.sv -----
// ----------------------------------------------------------------------------
// mts_intf
// Command and response channels of the min tracking stack.
// ----------------------------------------------------------------------------
interface mts_cmd_if;
	logic                                      valid;
	logic                                      ready;
	logic [1:0]                                opcode;
	logic signed [mts_pkg::DATA_W-1:0]         value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mts_rsp_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [mts_pkg::DATA_W-1:0]         top_value;
	logic signed [mts_pkg::DATA_W-1:0]         min_value;
	logic                                      is_empty;
	logic [1:0]                                error_code;

	modport source (output valid, output top_value, output min_value,
		output is_empty, output error_code, input ready);
	modport sink   (input valid, input top_value, input min_value,
		input is_empty, input error_code, output ready);
endinterface

// ----- src/mts_ram.sv -----
// ----------------------------------------------------------------------------
// mts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/mts_engine.sv -----
// ----------------------------------------------------------------------------
// mts_engine
// Sequencer, fill count, min register and cached top entry of the stack.
// ----------------------------------------------------------------------------
module mts_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	mts_cmd_if.sink                     cmd,
	output mts_pkg::mem_wr_t            mem_wr,
	output mts_pkg::mem_rd_t            mem_rd,
	input  logic [mts_pkg::WORD_W-1:0]  mem_rdata,
	output logic                        res_valid,
	input  logic                        res_ready,
	output mts_pkg::res_t               res
);

	mts_pkg::state_t state_q, state_d;

	logic [mts_pkg::CNT_W-1:0]         fill_q;
	logic signed [mts_pkg::DATA_W-1:0] min_q;
	logic signed [mts_pkg::WORD_W-1:0] top_q;   // raw word at fill_q - 1
	mts_pkg::err_t                     err_q;

	logic                              accept;
	logic                              do_push;
	logic                              do_pop;
	mts_pkg::err_t                     err_d;
	logic                              empty;
	logic                              full;
	logic                              val_gt_min;
	logic                              top_enc;
	logic signed [mts_pkg::WORD_W-1:0] val_ext;
	logic signed [mts_pkg::WORD_W-1:0] min_ext;
	logic signed [mts_pkg::WORD_W-1:0] enc_word;
	logic signed [mts_pkg::WORD_W-1:0] restore;
	logic signed [mts_pkg::WORD_W-1:0] push_word;

	assign empty      = (fill_q == '0);
	assign full       = (fill_q == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));
	assign val_ext    = {{2{cmd.value[mts_pkg::DATA_W-1]}}, cmd.value};
	assign min_ext    = {{2{min_q[mts_pkg::DATA_W-1]}}, min_q};
	assign val_gt_min = (cmd.value > min_q);
	assign top_enc    = (top_q < min_ext);
	// 2*value - min, 2*min - word
	assign enc_word   = {cmd.value[mts_pkg::DATA_W-1], cmd.value, 1'b0} - min_ext;
	assign restore    = {min_q[mts_pkg::DATA_W-1], min_q, 1'b0} - top_q;
	assign push_word  = (empty || val_gt_min) ? val_ext : enc_word;

	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		err_d   = mts_pkg::ERR_OK;
		case (cmd.opcode)
			mts_pkg::OP_PUSH: begin
				if (full) err_d = mts_pkg::ERR_FULL;
				else      do_push = 1'b1;
			end
			mts_pkg::OP_POP: begin
				if (empty) err_d = mts_pkg::ERR_EMPTY;
				else       do_pop = 1'b1;
			end
			default: ;
		endcase
	end

	assign accept = cmd.valid && cmd.ready;

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			mts_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					// popping down to a non-empty stack needs the new top from memory
					if (do_pop && fill_q != mts_pkg::CNT_W'(1)) state_d = mts_pkg::ST_READ;
					else                                        state_d = mts_pkg::ST_RESULT;
				end
			end
			mts_pkg::ST_READ: begin
				state_d = mts_pkg::ST_RESULT;
			end
			mts_pkg::ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) state_d = mts_pkg::ST_IDLE;
			end
			default: state_d = mts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			min_q  <= mts_pkg::MIN_RESET;
			err_q  <= mts_pkg::ERR_OK;
		end else if (accept) begin
			err_q <= err_d;
			if (do_push) begin
				fill_q <= fill_q + mts_pkg::CNT_W'(1);
				if (empty || !val_gt_min) min_q <= cmd.value;
			end else if (do_pop) begin
				fill_q <= fill_q - mts_pkg::CNT_W'(1);
				if (top_enc) min_q <= restore[mts_pkg::DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			top_q <= push_word;
		end else if (state_q == mts_pkg::ST_READ) begin
			top_q <= mem_rdata;
		end
	end

	assign mem_wr.we    = accept && do_push;
	assign mem_wr.waddr = fill_q[mts_pkg::PTR_W-1:0];
	assign mem_wr.wdata = push_word;
	assign mem_rd.re    = accept && do_pop;
	assign mem_rd.raddr = mts_pkg::PTR_W'(fill_q - mts_pkg::CNT_W'(2));

	assign res.top_value  = empty   ? '0 :
	                        top_enc ? min_q : top_q[mts_pkg::DATA_W-1:0];
	assign res.min_value  = min_q;
	assign res.is_empty   = empty;
	assign res.error_code = err_q;

endmodule

// ----- src/min_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO of signed 32-bit values that reports its minimum in constant time.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                     | transaction
//  --------+-----+---------------------------------------------+-------------------
//  cmd     | in  | opcode (push/pop/query), value              | one stack op
//  rsp     | out | top_value, min_value, is_empty, error_code  | one result per op
//
//  Sequence: push and query go straight from acceptance to the result state;
//  pop passes a read state first for the synchronous read of the new top
//  entry, except when the pop empties the stack or finds it already empty.
//  One operation is in flight at a time.
//  Reset: arst_n clears fill count, error code and sequencer; the minimum
//  resets to the largest positive value. Entry memory needs no clearing.
//  Stalls: rsp has an output register, so a new command is taken while the
//  previous result waits; the sequencer holds only when it has a result ready
//  and that register is still full.
//
module min_tracking_stack (
	input  logic      clk,
	input  logic      arst_n,
	mts_cmd_if.sink   cmd,
	mts_rsp_if.source rsp
);

	mts_pkg::mem_wr_t             mem_wr;
	mts_pkg::mem_rd_t             mem_rd;
	logic [mts_pkg::WORD_W-1:0]   mem_rdata;
	logic                         res_valid;
	logic                         res_ready;
	mts_pkg::res_t                res;

	logic                         out_valid_q;
	mts_pkg::res_t                out_q;

	// Entry store: each word is either a plain value (sign extended) or the
	// encoding 2*value - old_min of a value that lowered the minimum.
	mts_ram #(
		.WIDTH(mts_pkg::WORD_W),
		.DEPTH(mts_pkg::STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_wr.we),
		.waddr(mem_wr.waddr),
		.wdata(mem_wr.wdata),
		.re   (mem_rd.re),
		.raddr(mem_rd.raddr),
		.rdata(mem_rdata)
	);

	mts_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mem_wr   (mem_wr),
		.mem_rd   (mem_rd),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register: free when empty or drained this cycle
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.top_value  = out_q.top_value;
	assign rsp.min_value  = out_q.min_value;
	assign rsp.is_empty   = out_q.is_empty;
	assign rsp.error_code = out_q.error_code;

endmodule

// ----- src/mts_checker.sv -----
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the min tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [mts_pkg::DATA_W-1:0] top_value,
	input logic                              is_empty,
	input logic [1:0]                        error_code
);

	// result holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped before transaction");

	// one operation in flight: no command taken right after another
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken back to back");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> top_value == '0)
		else $error("empty stack reports nonzero top");

	// a dropped push reports a non-empty stack, an ignored pop an empty one
	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (error_code != mts_pkg::ERR_FULL || !is_empty) &&
		              (error_code != mts_pkg::ERR_EMPTY || is_empty) &&
		              (error_code == mts_pkg::ERR_OK || error_code == mts_pkg::ERR_FULL ||
		               error_code == mts_pkg::ERR_EMPTY))
		else $error("error code inconsistent with stack state");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.top_value (rsp.top_value),
	.is_empty  (rsp.is_empty),
	.error_code(rsp.error_code)
);
